### hdl/fefxc_pkg.sv
// Shared types, byte codes and escape helpers for the flag/escape framer.
`default_nettype none
package fefxc_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] FLAG_BYTE    = 8'h7e;
    localparam logic [7:0] ESC_BYTE     = 8'h7d;
    localparam logic [7:0] ESC_FOR_FLAG = 8'h02;
    localparam logic [7:0] ESC_FOR_ESC  = 8'h01;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } t_out;

    // one classified request, as queued between front and back
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] check;      // frame check including this byte, used when last
        logic       open;       // opening flag goes first
        logic       last;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic logic needs_esc(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    function automatic logic [7:0] esc_lead(input logic [7:0] b);
        return needs_esc(b) ? ESC_BYTE : b;
    endfunction

    function automatic logic [7:0] esc_tail(input logic [7:0] b);
        return (b == FLAG_BYTE) ? ESC_FOR_FLAG : ESC_FOR_ESC;
    endfunction

endpackage
`default_nettype wire

### hdl/flag_escape_framer_xor_check_unit.sv
// Flag/escape framer with XOR check: each message byte request comes out as one
// byte per cycle on the output side unless i_ready holds it. A mid-frame byte gives
// one byte, an escaped byte two, and opening flag, check (1 or 2) and closing flag
// add 3 or 4 more, so a request gives 1 to 6 bytes from the single output register
// of the back end. The front end takes a new request every cycle while the queue
// (QUEUE_DEPTH requests) has room, so input and output stall on their own.
`default_nettype none
module flag_escape_framer_xor_check_unit #(
    parameter int unsigned QUEUE_DEPTH = fefxc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire fefxc_pkg::t_in  i_in,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output fefxc_pkg::t_out      o_out
);
    import fefxc_pkg::*;

    t_q_stat q_stat;
    t_entry  push_entry;
    t_entry  head;
    logic    push;
    logic    pop;

    fefxc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    fefxc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    fefxc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_out    (o_out)
    );

`ifndef SYNTHESIS
    a_close_is_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.frame_end |-> o_out.out_byte == FLAG_BYTE)
        else $error("frame_end on a byte other than the flag");

    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue both empty and full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("back end pops an empty queue");

    a_esc_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_out.frame_end && o_out.out_byte == ESC_BYTE
        |=> o_valid && (o_out.out_byte == ESC_FOR_FLAG || o_out.out_byte == ESC_FOR_ESC))
        else $error("escape byte not followed by its code");
`endif

endmodule
`default_nettype wire

### hdl/fefxc_front.sv
// Front end: accepts message bytes, tracks frame state and the running XOR check.
`default_nettype none
module fefxc_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire fefxc_pkg::t_in   i_in,
    input  wire fefxc_pkg::t_q_stat i_q_stat,
    output logic                  o_push,
    output fefxc_pkg::t_entry     o_entry
);
    import fefxc_pkg::*;

    logic       r_inside;
    logic [7:0] r_check;
    logic       n_inside;
    logic [7:0] n_check;
    logic [7:0] chk_now;

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;
    assign chk_now = (r_inside ? r_check : 8'h00) ^ i_in.data_byte;

    always_comb begin
        o_entry.data_byte = i_in.data_byte;
        o_entry.check     = chk_now;
        o_entry.open      = !r_inside;
        o_entry.last      = i_in.end_of_message;
    end

    always_comb begin
        n_inside = r_inside;
        n_check  = r_check;
        if (o_push) begin
            if (i_in.end_of_message) begin
                n_inside = 1'b0;
                n_check  = 8'h00;
            end else begin
                n_inside = 1'b1;
                n_check  = chk_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_check  <= 8'h00;
        end else begin
            r_inside <= n_inside;
            r_check  <= n_check;
        end
    end

endmodule
`default_nettype wire

### hdl/fefxc_queue.sv
// Small request queue between front and back, head shown without a read stage.
`default_nettype none
module fefxc_queue #(
    parameter int unsigned DEPTH = fefxc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire fefxc_pkg::t_entry i_entry,
    input  wire logic              i_pop,
    output fefxc_pkg::t_entry      o_head,
    output fefxc_pkg::t_q_stat     o_stat
);
    import fefxc_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_comb begin
        n_wr  = do_push ? ((r_wr == LAST_PTR) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = do_pop  ? ((r_rd == LAST_PTR) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### hdl/fefxc_back.sv
// Back end: walks each queued request through flag (if open), escaped byte, and check and close (if last).
`default_nettype none
module fefxc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fefxc_pkg::t_entry  i_head,
    input  wire fefxc_pkg::t_q_stat i_q_stat,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output fefxc_pkg::t_out         o_out
);
    import fefxc_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_DATA,
        PH_DATA_ESC,
        PH_CHK,
        PH_CHK_ESC,
        PH_CLOSE
    } t_phase;

    t_phase r_phase;
    t_phase n_phase;
    logic   r_ov;
    logic   n_ov;
    t_out   r_out;
    t_out   n_out;
    logic   out_free;
    logic   emit;

    assign out_free = !r_ov || i_ready;
    assign o_valid  = r_ov;
    assign o_out    = r_out;

    always_comb begin
        n_phase         = r_phase;
        emit            = 1'b0;
        o_pop           = 1'b0;
        n_out.out_byte  = FLAG_BYTE;
        n_out.frame_end = 1'b0;
        if (!i_q_stat.empty && out_free) begin
            emit = 1'b1;
            case (r_phase)
                PH_FIRST, PH_DATA: begin
                    if (r_phase == PH_FIRST && i_head.open) begin
                        n_out.out_byte = FLAG_BYTE;
                        n_phase        = PH_DATA;
                    end else begin
                        n_out.out_byte = esc_lead(i_head.data_byte);
                        if (needs_esc(i_head.data_byte)) begin
                            n_phase = PH_DATA_ESC;
                        end else if (i_head.last) begin
                            n_phase = PH_CHK;
                        end else begin
                            n_phase = PH_FIRST;
                            o_pop   = 1'b1;
                        end
                    end
                end
                PH_DATA_ESC: begin
                    n_out.out_byte = esc_tail(i_head.data_byte);
                    if (i_head.last) begin
                        n_phase = PH_CHK;
                    end else begin
                        n_phase = PH_FIRST;
                        o_pop   = 1'b1;
                    end
                end
                PH_CHK: begin
                    n_out.out_byte = esc_lead(i_head.check);
                    n_phase = needs_esc(i_head.check) ? PH_CHK_ESC : PH_CLOSE;
                end
                PH_CHK_ESC: begin
                    n_out.out_byte = esc_tail(i_head.check);
                    n_phase        = PH_CLOSE;
                end
                PH_CLOSE: begin
                    n_out.out_byte  = FLAG_BYTE;
                    n_out.frame_end = 1'b1;
                    n_phase         = PH_FIRST;
                    o_pop           = 1'b1;
                end
                default: begin
                    emit    = 1'b0;
                    n_phase = PH_FIRST;
                end
            endcase
        end
        n_ov = out_free ? emit : r_ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ov    <= n_ov;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
